@@ design/ued_pkg.sv @@
// Package for the Unicode escape decoder: transaction payload types and
// the byte codes and escape lengths shared by the decoder core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ued_pkg;

  localparam int HOLD_CAP  = 10;
  localparam int CNT_W     = $clog2(HOLD_CAP + 1);
  localparam int SHORT_LEN = 6;
  localparam int LONG_LEN  = 10;
  localparam int CODE_W    = 32;

  localparam logic [7:0] BSLASH  = 8'h5C;
  localparam logic [7:0] LOWER_U = 8'h75;
  localparam logic [7:0] UPPER_U = 8'h55;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic              final_code;
  } out_t;

endpackage

`default_nettype wire

@@ design/unicode_escape_decoder_core.sv @@
// Unicode escape decoder core: hold buffer, escape recognition, hex digit
// decoding and the result register. Depends on ued_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one text byte per cycle and gives one character code per
// cycle through a registered output while neither side stalls. A backslash
// that may open an escape is held in a ten-byte buffer until the escape is
// complete, so a byte can be taken in every cycle while the buffer has room
// or a code leaves. After the last byte of a string has been taken, input
// is paused until every held byte has been flushed; an unfinished escape
// is then emitted byte by byte through the single-result output register,
// which sets the drain rate. No clearing pass is needed after reset.
module unicode_escape_decoder_core
  import ued_pkg::*;
#(
  parameter int CHAR_BITS = 32
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  in_t  in_data,
  output logic       out_valid,
  input  wire  logic out_ready,
  output out_t       out_data
);

  localparam logic [63:0]       MaskWide = (64'd1 << CHAR_BITS) - 64'd1;
  localparam logic [CODE_W-1:0] CodeMask = MaskWide[CODE_W-1:0];

  typedef enum logic [1:0] {
    ACT_WAIT,
    ACT_LIT,
    ACT_DEC_SHORT,
    ACT_DEC_LONG
  } act_t;

  logic [7:0]       buf_r   [HOLD_CAP];
  logic [7:0]       buf_nxt [HOLD_CAP];
  logic [7:0]       sh      [HOLD_CAP];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             par_r, par_nxt;
  logic             endp_r, endp_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  act_t              act;
  logic              fire;
  logic              accept;
  logic              last;
  logic [CNT_W-1:0]  cons;
  logic [CNT_W-1:0]  wpos;
  logic [3:0]        ndig;
  logic [CODE_W-1:0] acc;
  logic [4:0]        hv;
  logic              stop;
  logic              inv;
  logic              dpar;
  logic              par_after;
  logic [CODE_W-1:0] code;

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b inside {[8'h30:8'h39]}) v = 5'(b - 8'h30);
    else if (b inside {[8'h41:8'h46]}) v = 5'(b - 8'h41 + 8'd10);
    else if (b inside {[8'h61:8'h66]}) v = 5'(b - 8'h61 + 8'd10);
    return v;
  endfunction

  always_comb begin
    act = ACT_WAIT;
    if (cnt_r != '0) begin
      if (buf_r[0] != BSLASH) begin
        act = ACT_LIT;
      end else if (cnt_r < CNT_W'(2)) begin
        act = endp_r ? ACT_LIT : ACT_WAIT;
      end else if (buf_r[1] == LOWER_U && !par_r) begin
        if (cnt_r >= CNT_W'(SHORT_LEN)) act = ACT_DEC_SHORT;
        else act = endp_r ? ACT_LIT : ACT_WAIT;
      end else if (buf_r[1] == UPPER_U) begin
        if (cnt_r >= CNT_W'(LONG_LEN)) act = ACT_DEC_LONG;
        else act = endp_r ? ACT_LIT : ACT_WAIT;
      end else begin
        act = ACT_LIT;
      end
    end
  end

  always_comb begin
    ndig = (act == ACT_DEC_LONG) ? 4'(LONG_LEN - 2) : 4'(SHORT_LEN - 2);
    acc  = '0;
    hv   = '0;
    stop = 1'b0;
    inv  = 1'b0;
    dpar = 1'b0;
    for (int i = 0; i < LONG_LEN - 2; i++) begin
      if (4'(i) < ndig) begin
        dpar = (buf_r[2+i] == BSLASH) ? ~dpar : 1'b0;
        if (!stop) begin
          hv = hex_val(buf_r[2+i]);
          if (buf_r[2+i] == 8'h00) begin
            stop = 1'b1;
          end else if (hv > 5'd15) begin
            inv  = 1'b1;
            stop = 1'b1;
          end else begin
            acc = {acc[CODE_W-5:0], hv[3:0]};
          end
        end
      end
    end
  end

  always_comb begin
    fire = (act != ACT_WAIT) && (!out_valid_r || out_ready);
    case (act)
      ACT_LIT: begin
        cons      = CNT_W'(1);
        code      = {{(CODE_W-8){1'b0}}, buf_r[0]};
        par_after = (buf_r[0] == BSLASH) ? ~par_r : 1'b0;
      end
      ACT_DEC_SHORT: begin
        cons      = CNT_W'(SHORT_LEN);
        code      = inv ? '1 : acc;
        par_after = dpar;
      end
      ACT_DEC_LONG: begin
        cons      = CNT_W'(LONG_LEN);
        code      = inv ? '1 : acc;
        par_after = dpar;
      end
      default: begin
        cons      = '0;
        code      = '0;
        par_after = par_r;
      end
    endcase
    if (!fire) cons = '0;
    last = endp_r && (cnt_r == cons);

    in_ready = !endp_r && ((cnt_r < CNT_W'(HOLD_CAP)) || fire);
    accept   = in_valid && in_ready;
    wpos     = cnt_r - cons;

    for (int i = 0; i < HOLD_CAP; i++) sh[i] = buf_r[i];
    if (cons == CNT_W'(1)) begin
      for (int i = 0; i < HOLD_CAP - 1; i++) sh[i] = buf_r[i+1];
    end else if (cons == CNT_W'(SHORT_LEN)) begin
      for (int i = 0; i < HOLD_CAP - SHORT_LEN; i++) sh[i] = buf_r[i+SHORT_LEN];
    end
    for (int i = 0; i < HOLD_CAP; i++) begin
      buf_nxt[i] = (accept && wpos == CNT_W'(i)) ? in_data.char_in : sh[i];
    end

    cnt_nxt = cnt_r - cons + CNT_W'(accept);

    par_nxt  = par_r;
    endp_nxt = endp_r;
    if (fire) par_nxt = last ? 1'b0 : par_after;
    if (fire && last) endp_nxt = 1'b0;
    else if (accept && in_data.end_of_text) endp_nxt = 1'b1;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fire) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.code_out   = code & CodeMask;
      out_data_nxt.final_code = last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      par_r       <= 1'b0;
      endp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      par_r       <= par_nxt;
      endp_r      <= endp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HOLD_CAP))
    else $error("hold buffer count exceeds capacity");

  a_end_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    endp_r |-> cnt_r != '0)
    else $error("end of string pending with an empty hold buffer");

  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> cnt_r == '0 && !par_r && !endp_r)
    else $error("state not cleared after the final code of a string");

  a_end_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_text |=> endp_r)
    else $error("final byte transaction did not start a flush");

endmodule

`default_nettype wire
